/* sv/dac_pkg.sv */
// shared types, codes and widths of the door alarm controller
`timescale 1ns / 1ps
package dac_pkg;

  localparam int TIME_W    = 32;
  localparam int UID_W     = 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BUZZER_DURATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_WINDOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECISION_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEEN_WINDOW      = 3'd4;

  localparam logic [CFG_W-1:0] RST_BUZZER_DURATION  = 24'd60000;
  localparam logic [CFG_W-1:0] RST_GREEN_WINDOW     = 24'd10000;
  localparam logic [CFG_W-1:0] RST_SUPPRESS_WINDOW  = 24'd300000;
  localparam logic [CFG_W-1:0] RST_DECISION_TIMEOUT = 24'd30000;
  localparam logic [CFG_W-1:0] RST_SEEN_WINDOW      = 24'd1500;

  localparam logic [1:0] VOTE_KNOWN   = 2'd1;
  localparam logic [1:0] VOTE_UNKNOWN = 2'd2;

  localparam logic [1:0] DEC_TRIGGER = 2'd1;
  localparam logic [1:0] DEC_CANCEL  = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_VOTE     = 3'd1,
    OP_DOOR     = 3'd2,
    OP_PRESENCE = 3'd3,
    OP_DECISION = 3'd4,
    OP_COMMAND  = 3'd5,
    OP_LINK     = 3'd6,
    OP_SEEN     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    LVL_GREEN  = 2'd0,
    LVL_YELLOW = 2'd1,
    LVL_RED    = 2'd2
  } lvl_t;

  typedef enum logic [1:0] {
    FACE_NONE     = 2'd0,
    FACE_MATCHED  = 2'd1,
    FACE_STRANGER = 2'd2
  } face_t;

  typedef struct packed {
    logic [CFG_W-1:0] buzzer_duration;
    logic [CFG_W-1:0] green_window;
    logic [CFG_W-1:0] suppress_window;
    logic [CFG_W-1:0] decision_timeout;
    logic [CFG_W-1:0] seen_window;
  } cfg_t;

  typedef struct packed {
    op_t               operation;
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        vote_kind;
    logic [UID_W-1:0]  user_id;
    logic              event_flag;
    logic [1:0]        decision;
  } item_t;

  typedef struct packed {
    logic              alarm_active;
    logic              buzzer_active;
    logic [TIME_W-1:0] buzzer_start;
    logic              waiting;
    logic [TIME_W-1:0] decision_start;
    logic              known_flag;
    logic [TIME_W-1:0] known_time;
    face_t             face_status;
    logic              credit_done;
    logic [UID_W-1:0]  pending_user;
    logic [UID_W-1:0]  seen_user;
    logic [TIME_W-1:0] seen_time;
    logic              door_is_open;
    logic              occupied_flag;
    logic              decider_online;
    logic              suppress_flag;
    logic [TIME_W-1:0] suppress_start;
    lvl_t              level;
  } state_t;

  typedef struct packed {
    lvl_t             alert_level;
    logic             alarm_on;
    logic             buzzer_on;
    logic             awaiting_decision;
    logic             suppressing;
    logic             alert_raised;
    logic             alarm_cancelled;
    logic             buzzer_silenced;
    logic             user_confirmed;
    logic             door_event;
    logic [UID_W-1:0] door_user;
  } res_t;

endpackage

/* sv/dac_cfg_regs.sv */
// configuration registers of the door alarm controller
`timescale 1ns / 1ps
module dac_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [dac_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [dac_pkg::CFG_W-1:0]     wr_data,
  output dac_pkg::cfg_t                 cfg
);
  import dac_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_BUZZER_DURATION:  cfg_nxt.buzzer_duration  = wr_data;
        CFG_GREEN_WINDOW:     cfg_nxt.green_window     = wr_data;
        CFG_SUPPRESS_WINDOW:  cfg_nxt.suppress_window  = wr_data;
        CFG_DECISION_TIMEOUT: cfg_nxt.decision_timeout = wr_data;
        CFG_SEEN_WINDOW:      cfg_nxt.seen_window      = wr_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buzzer_duration  <= RST_BUZZER_DURATION;
      cfg_r.green_window     <= RST_GREEN_WINDOW;
      cfg_r.suppress_window  <= RST_SUPPRESS_WINDOW;
      cfg_r.decision_timeout <= RST_DECISION_TIMEOUT;
      cfg_r.seen_window      <= RST_SEEN_WINDOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/dac_step.sv */
// event decode and next-state logic for one transaction
`timescale 1ns / 1ps
module dac_step (
  input  dac_pkg::item_t  item,
  input  dac_pkg::state_t cur,
  input  dac_pkg::cfg_t   cfg,
  output dac_pkg::state_t nxt,
  output dac_pkg::res_t   res
);
  import dac_pkg::*;

  typedef struct packed {
    state_t s;
    logic   alert;
    logic   cancelled;
    logic   silenced;
  } work_t;

  function automatic logic in_window(logic [TIME_W-1:0] now, logic [TIME_W-1:0] start,
                                     logic [CFG_W-1:0] win);
    logic [TIME_W-1:0] diff;
    diff = now - start;
    return diff < {{(TIME_W-CFG_W){1'b0}}, win};
  endfunction

  function automatic lvl_t calc_level(state_t s, logic [TIME_W-1:0] now,
                                      logic [CFG_W-1:0] gw);
    lvl_t l;
    if (s.alarm_active) l = LVL_RED;
    else if (s.known_flag && in_window(now, s.known_time, gw)) l = LVL_GREEN;
    else if (s.decider_online && s.occupied_flag) l = LVL_YELLOW;
    else l = LVL_RED;
    return l;
  endfunction

  function automatic work_t do_trigger(work_t w, logic [TIME_W-1:0] now);
    work_t r;
    r = w;
    if (!r.s.alarm_active) begin
      r.s.alarm_active  = 1'b1;
      r.s.buzzer_active = 1'b1;
      r.s.buzzer_start  = now;
      r.s.waiting       = 1'b0;
      r.s.level         = LVL_RED;
      r.alert           = 1'b1;
    end
    return r;
  endfunction

  function automatic work_t do_cancel(work_t w, logic [TIME_W-1:0] now,
                                      logic [CFG_W-1:0] gw);
    work_t r;
    r = w;
    if (r.s.alarm_active) begin
      r.s.alarm_active = 1'b0;
      r.s.known_flag   = 1'b0;
      r.s.face_status  = FACE_NONE;
      if (r.s.buzzer_active) begin
        r.s.buzzer_active = 1'b0;
        r.silenced        = 1'b1;
      end
      r.s.level   = calc_level(r.s, now, gw);
      r.cancelled = 1'b1;
    end
    return r;
  endfunction

  work_t             w;
  logic              n_known;
  logic              n_door;
  logic [UID_W-1:0]  door_user;
  logic [TIME_W-1:0] now;
  logic              sup_live;

  always_comb begin
    now       = item.now_ms;
    w.s       = cur;
    w.alert   = 1'b0;
    w.cancelled = 1'b0;
    w.silenced  = 1'b0;
    n_known   = 1'b0;
    n_door    = 1'b0;
    door_user = '0;
    sup_live  = cur.suppress_flag && in_window(now, cur.suppress_start, cfg.suppress_window);

    unique case (item.operation)
      OP_TICK: begin
        if (w.s.suppress_flag && !in_window(now, w.s.suppress_start, cfg.suppress_window)) begin
          w.s.suppress_flag = 1'b0;
        end
        if (w.s.known_flag && !in_window(now, w.s.known_time, cfg.green_window)) begin
          w.s.known_flag  = 1'b0;
          w.s.face_status = FACE_NONE;
          w.s.credit_done = 1'b0;
          w.s.level       = calc_level(w.s, now, cfg.green_window);
        end
        if (w.s.alarm_active && w.s.buzzer_active &&
            !in_window(now, w.s.buzzer_start, cfg.buzzer_duration)) begin
          w = do_cancel(w, now, cfg.green_window);
        end
        if (w.s.waiting && !in_window(now, w.s.decision_start, cfg.decision_timeout)) begin
          w.s.waiting = 1'b0;
          w = do_trigger(w, now);
        end
      end
      OP_VOTE: begin
        unique case (item.vote_kind)
          VOTE_KNOWN: begin
            w.s.face_status  = FACE_MATCHED;
            w.s.known_flag   = 1'b1;
            w.s.known_time   = now;
            w.s.credit_done  = 1'b0;
            w.s.pending_user = item.user_id;
            w.s.waiting      = 1'b0;
            n_known          = 1'b1;
            w = do_cancel(w, now, cfg.green_window);
            w.s.level = calc_level(w.s, now, cfg.green_window);
          end
          VOTE_UNKNOWN: begin
            w.s.face_status = FACE_STRANGER;
            w.s.level       = calc_level(w.s, now, cfg.green_window);
            if (!sup_live) begin
              if (w.s.level == LVL_RED) begin
                w = do_trigger(w, now);
              end else if (!w.s.alarm_active && !w.s.waiting) begin
                w.s.waiting        = 1'b1;
                w.s.decision_start = now;
                w.alert            = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      OP_DOOR: begin
        w.s.door_is_open = item.event_flag;
        n_door           = 1'b1;
        if (item.event_flag && !cur.credit_done) begin
          if (cur.pending_user != '0 && in_window(now, cur.known_time, cfg.green_window)) begin
            door_user = cur.pending_user;
          end else if (cur.seen_user != '0 &&
                       in_window(now, cur.seen_time, cfg.seen_window)) begin
            door_user = cur.seen_user;
          end
          if (door_user != '0) w.s.credit_done = 1'b1;
        end
        if (!item.event_flag) begin
          w.s.pending_user = '0;
          w = do_cancel(w, now, cfg.green_window);
        end
      end
      OP_PRESENCE: begin
        w.s.occupied_flag = item.event_flag;
        w.s.level         = calc_level(w.s, now, cfg.green_window);
      end
      OP_DECISION: begin
        unique case (item.decision)
          DEC_TRIGGER: begin
            if (w.s.waiting) begin
              w.s.waiting = 1'b0;
              w = do_trigger(w, now);
            end
          end
          DEC_CANCEL: begin
            if (w.s.waiting || w.s.alarm_active) begin
              w.s.suppress_flag  = 1'b1;
              w.s.suppress_start = now;
            end
            w.s.waiting = 1'b0;
            w = do_cancel(w, now, cfg.green_window);
          end
          default: ;
        endcase
      end
      OP_COMMAND: begin
        unique case (item.decision)
          DEC_TRIGGER: begin
            w.s.waiting = 1'b0;
            w = do_trigger(w, now);
          end
          DEC_CANCEL: begin
            w.s.waiting        = 1'b0;
            w.s.suppress_flag  = 1'b1;
            w.s.suppress_start = now;
            w = do_cancel(w, now, cfg.green_window);
          end
          default: ;
        endcase
      end
      OP_LINK: begin
        if (w.s.decider_online != item.event_flag) begin
          w.s.decider_online = item.event_flag;
          w.s.level          = calc_level(w.s, now, cfg.green_window);
          if (!item.event_flag && w.s.waiting) begin
            w.s.waiting = 1'b0;
            w = do_trigger(w, now);
          end
        end
      end
      OP_SEEN: begin
        if (item.user_id != '0) begin
          w.s.seen_user = item.user_id;
          w.s.seen_time = now;
        end
      end
      default: ;
    endcase

    nxt                   = w.s;
    res.alert_level       = w.s.level;
    res.alarm_on          = w.s.alarm_active;
    res.buzzer_on         = w.s.buzzer_active;
    res.awaiting_decision = w.s.waiting;
    res.suppressing       = w.s.suppress_flag;
    res.alert_raised      = w.alert;
    res.alarm_cancelled   = w.cancelled;
    res.buzzer_silenced   = w.silenced;
    res.user_confirmed    = n_known;
    res.door_event        = n_door;
    res.door_user         = door_user;
  end

endmodule

/* sv/door_alarm_controller.sv */
// top level of the door alarm controller: input register, state, result register
`timescale 1ns / 1ps
// Door alarm controller. Takes one event transaction per clock while in_stall is low and
// returns one result transaction per event, in order. An event is held in an input
// register, processed combinationally by the next-state logic against the stored alarm
// state, and its result is loaded into the output register, which drives out_valid, when
// the event advances. Sustained rate is one event per cycle; in_stall rises only when
// the result register is full and out_stall holds it. Timeouts use wrapping 32-bit
// millisecond differences against the 24-bit windows. The configuration port is always
// ready; write it only while no event is in flight. Register indexes above 4 are ignored.
module door_alarm_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_operation,
  input  logic [dac_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [1:0]                    in_vote_kind,
  input  logic [dac_pkg::UID_W-1:0]     in_user_id,
  input  logic                          in_event_flag,
  input  logic [1:0]                    in_decision,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_alert_level,
  output logic                          out_alarm_on,
  output logic                          out_buzzer_on,
  output logic                          out_awaiting_decision,
  output logic                          out_suppressing,
  output logic                          out_alert_raised,
  output logic                          out_alarm_cancelled,
  output logic                          out_buzzer_silenced,
  output logic                          out_user_confirmed,
  output logic                          out_door_event,
  output logic [dac_pkg::UID_W-1:0]     out_door_user,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dac_pkg::CFG_W-1:0]     cfg_data
);
  import dac_pkg::*;

  cfg_t   cfg;
  item_t  in_item_r;
  logic   in_full_r;
  logic   in_full_nxt;
  res_t   out_res_r;
  logic   out_full_r;
  logic   out_full_nxt;
  state_t state_r;
  state_t state_nxt;
  state_t state_rst;
  res_t   step_res;
  logic   accept;
  logic   advance;

  assign cfg_ready = 1'b1;

  dac_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dac_step u_step (
    .item (in_item_r),
    .cur  (state_r),
    .cfg  (cfg),
    .nxt  (state_nxt),
    .res  (step_res)
  );

  assign advance  = in_full_r && (!out_full_r || !out_stall);
  assign in_stall = in_full_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_full_nxt = in_full_r;
    if (accept) in_full_nxt = 1'b1;
    else if (advance) in_full_nxt = 1'b0;
    out_full_nxt = out_full_r;
    if (advance) out_full_nxt = 1'b1;
    else if (!out_stall) out_full_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r  <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      in_full_r  <= in_full_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.operation  <= op_t'(in_operation);
      in_item_r.now_ms     <= in_now_ms;
      in_item_r.vote_kind  <= in_vote_kind;
      in_item_r.user_id    <= in_user_id;
      in_item_r.event_flag <= in_event_flag;
      in_item_r.decision   <= in_decision;
    end
    if (advance) out_res_r <= step_res;
  end

  always_comb begin
    state_rst             = '0;
    state_rst.face_status = FACE_NONE;
    state_rst.level       = LVL_RED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= state_rst;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  assign out_valid             = out_full_r;
  assign out_alert_level       = out_res_r.alert_level;
  assign out_alarm_on          = out_res_r.alarm_on;
  assign out_buzzer_on         = out_res_r.buzzer_on;
  assign out_awaiting_decision = out_res_r.awaiting_decision;
  assign out_suppressing       = out_res_r.suppressing;
  assign out_alert_raised      = out_res_r.alert_raised;
  assign out_alarm_cancelled   = out_res_r.alarm_cancelled;
  assign out_buzzer_silenced   = out_res_r.buzzer_silenced;
  assign out_user_confirmed    = out_res_r.user_confirmed;
  assign out_door_event        = out_res_r.door_event;
  assign out_door_user         = out_res_r.door_user;

`ifndef NO_ASSERTIONS
  a_alarm_red: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.alarm_active |-> state_r.level == LVL_RED)
    else $error("alarm active without red level");

  a_alarm_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.alarm_active && state_r.waiting))
    else $error("decision pending while alarm active");

  a_buzzer_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.buzzer_active |-> state_r.alarm_active)
    else $error("buzzer sounding without alarm");

  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("processed transaction not presented");

  a_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_full_r |-> !in_stall)
    else $error("input stalled with empty input register");
`endif

endmodule
